// File: hdl/grid_bfs_next_step_defines.svh
// Assertion macros shared by the grid search RTL.
// No dependencies; files that check their own logic include this header.
`ifndef GRID_BFS_NEXT_STEP_DEFINES_SVH
`define GRID_BFS_NEXT_STEP_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising edge outside reset.
`define GBFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition that must never be seen at a rising edge outside reset.
`define GBFS_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define GBFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define GBFS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/gbfs_pkg.sv
// Shared types and constants for the grid breadth-first search block.
// No dependencies; used by every module of the block but gbfs_ram.
package gbfs_pkg;

  // Register file geometry.
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam int REG_W  = 5;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes (address bit 2).
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [REG_W-1:0] GRID_ROWS_RST = 5'd10;
  localparam logic [REG_W-1:0] GRID_COLS_RST = 5'd10;

  typedef struct packed {
    logic       op;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic       cell_blocked;
    logic [3:0] src_row;
    logic [3:0] src_col;
    logic [3:0] dst_row;
    logic [3:0] dst_col;
  } in_item_t;

  typedef struct packed {
    logic [3:0] next_row;
    logic [3:0] next_col;
    logic       found;
  } out_item_t;

  // Effective grid extent, already limited to the map size.
  typedef struct packed {
    logic [REG_W-1:0] rows;
    logic [REG_W-1:0] cols;
  } grid_dim_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEED,
    S_POP,
    S_CHECK,
    S_NBR,
    S_OUT
  } state_t;

endpackage

// File: hdl/gbfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gbfs_cfg.sv
// Configuration registers (grid rows and columns) behind an APB-style port.
// Depends on gbfs_pkg for register indexes, reset values and grid_dim_t.
module gbfs_cfg
  import gbfs_pkg::*;
#(
  parameter int GRID_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output grid_dim_t         dim
);

  logic [REG_W-1:0] rows_r;
  logic [REG_W-1:0] cols_r;
  logic             wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= GRID_ROWS_RST;
      cols_r <= GRID_COLS_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ROWS: rows_r <= pwdata[REG_W-1:0];
        REG_COLS: cols_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register values.
  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = APB_DW'(rows_r);
      REG_COLS: prdata = APB_DW'(cols_r);
      default:  prdata = '0;
    endcase
  end

  // The search never looks past the stored map.
  always_comb begin
    dim.rows = (32'(rows_r) < GRID_SIZE) ? rows_r : REG_W'(GRID_SIZE);
    dim.cols = (32'(cols_r) < GRID_SIZE) ? cols_r : REG_W'(GRID_SIZE);
  end

endmodule

// File: hdl/gbfs_engine.sv
// Search engine: blocked map, visited map and cell queue in RAMs, plus the
// sequencer that clears, seeds and runs the breadth-first search.
// Depends on gbfs_pkg, gbfs_ram and the assertion macros header.
`include "grid_bfs_next_step_defines.svh"
module gbfs_engine
  import gbfs_pkg::*;
#(
  parameter int GRID_SIZE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  grid_dim_t dim,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int MAW   = $clog2(CELLS);
  localparam int CW    = (GRID_SIZE > 16) ? $clog2(GRID_SIZE) : 4;
  localparam int NW    = CW + 1;
  localparam int QD    = CELLS + 1;
  localparam int QAW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);

  localparam logic [1:0] NB_DOWN  = 2'd0;
  localparam logic [1:0] NB_RIGHT = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_UP    = 2'd3;

  localparam logic [NW-1:0] ONE_N = NW'(1);

  function automatic logic [MAW-1:0] cell_idx(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
    return MAW'(32'(r) * GRID_SIZE + 32'(c));
  endfunction

  // True when two cells lie within Chebyshev distance one.
  function automatic logic cheb_near(input logic [CW-1:0] ar, input logic [CW-1:0] ac,
                                     input logic [CW-1:0] br, input logic [CW-1:0] bc);
    logic [CW-1:0] dr;
    logic [CW-1:0] dc;
    dr = (ar >= br) ? ar - br : br - ar;
    dc = (ac >= bc) ? ac - bc : bc - ac;
    return (dr <= CW'(1)) && (dc <= CW'(1));
  endfunction

  state_t          state_r, state_nxt;
  logic [MAW-1:0]  clr_addr_r, clr_addr_nxt;
  logic            init_r, init_nxt;
  logic [QCW-1:0]  head_r, head_nxt;
  logic [QCW-1:0]  tail_r, tail_nxt;
  logic [CW-1:0]   src_row_r, src_row_nxt, src_col_r, src_col_nxt;
  logic [CW-1:0]   dst_row_r, dst_row_nxt, dst_col_r, dst_col_nxt;
  logic [CW-1:0]   cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [1:0]      nbr_k_r, nbr_k_nxt;
  logic            nbr_ok_r, nbr_ok_nxt;
  logic [CW-1:0]   nbr_row_r, nbr_row_nxt, nbr_col_r, nbr_col_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // Memory port signals.
  logic            b_we, b_wdata, b_rdata;
  logic [MAW-1:0]  b_waddr;
  logic            v_we, v_wdata, v_rdata;
  logic [MAW-1:0]  v_waddr;
  logic [MAW-1:0]  map_raddr;
  logic            q_we;
  logic [QAW-1:0]  q_waddr, q_raddr;
  logic [2*CW-1:0] q_wdata, q_rdata;

  // Neighbor issue path.
  logic [1:0]      iss_k;
  logic [CW-1:0]   base_row, base_col;
  logic [NW-1:0]   row_e, col_e;
  logic            pos_ok, iss_ok;
  logic [CW-1:0]   iss_row, iss_col;
  logic            in_xfer, out_load;

  // Conditions watched by the checks.
  logic            query_xfer, res_found, res_near;

  gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blocked (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(map_raddr), .rdata(b_rdata)
  );

  gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(map_raddr), .rdata(v_rdata)
  );

  gbfs_ram #(.WIDTH(2*CW), .DEPTH(QD)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Neighbor whose map bits are read this cycle, with its bounds check.
  always_comb begin
    iss_k    = (state_r == S_CHECK) ? NB_DOWN : nbr_k_r + 2'd1;
    base_row = (state_r == S_CHECK) ? q_rdata[2*CW-1:CW] : cur_row_r;
    base_col = (state_r == S_CHECK) ? q_rdata[CW-1:0] : cur_col_r;
    row_e    = NW'(base_row);
    col_e    = NW'(base_col);
    pos_ok   = 1'b1;
    case (iss_k)
      NB_DOWN:  row_e = NW'(base_row) + ONE_N;
      NB_RIGHT: col_e = NW'(base_col) + ONE_N;
      NB_LEFT: begin
        pos_ok = (base_col != '0);
        col_e  = NW'(base_col) - ONE_N;
      end
      NB_UP: begin
        pos_ok = (base_row != '0);
        row_e  = NW'(base_row) - ONE_N;
      end
      default: ;
    endcase
    iss_ok  = pos_ok && (row_e < NW'(dim.rows)) && (col_e < NW'(dim.cols));
    iss_row = row_e[CW-1:0];
    iss_col = col_e[CW-1:0];
  end

  assign map_raddr = cell_idx(iss_row, iss_col);
  assign q_raddr   = head_r[QAW-1:0];

  // Sequencer: next state, memory writes and result capture.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    init_nxt     = init_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    src_row_nxt  = src_row_r;
    src_col_nxt  = src_col_r;
    dst_row_nxt  = dst_row_r;
    dst_col_nxt  = dst_col_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    nbr_k_nxt    = nbr_k_r;
    nbr_ok_nxt   = nbr_ok_r;
    nbr_row_nxt  = nbr_row_r;
    nbr_col_nxt  = nbr_col_r;
    res_nxt      = res_r;
    b_we         = 1'b0;
    b_waddr      = clr_addr_r;
    b_wdata      = 1'b0;
    v_we         = 1'b0;
    v_waddr      = cell_idx(nbr_row_r, nbr_col_r);
    v_wdata      = 1'b1;
    q_we         = 1'b0;
    q_waddr      = tail_r[QAW-1:0];
    q_wdata      = {nbr_row_r, nbr_col_r};

    case (state_r)
      // Sweep the visited map; after reset the blocked map too.
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_addr_r;
        v_wdata = 1'b0;
        b_we    = init_r;
        if (clr_addr_r == MAW'(CELLS - 1)) begin
          clr_addr_nxt = '0;
          init_nxt     = 1'b0;
          state_nxt    = init_r ? S_IDLE : S_SEED;
        end else begin
          clr_addr_nxt = clr_addr_r + MAW'(1);
        end
      end

      // Take a load or start a query.
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.op == OP_LOAD) begin
            b_we    = (32'(in_data.cell_row) < GRID_SIZE) &&
                      (32'(in_data.cell_col) < GRID_SIZE);
            b_waddr = cell_idx(CW'(in_data.cell_row), CW'(in_data.cell_col));
            b_wdata = in_data.cell_blocked;
          end else begin
            src_row_nxt = CW'(in_data.src_row);
            src_col_nxt = CW'(in_data.src_col);
            dst_row_nxt = CW'(in_data.dst_row);
            dst_col_nxt = CW'(in_data.dst_col);
            state_nxt   = S_CLEAR;
          end
        end
      end

      // The destination is always queued, marked only inside the map.
      S_SEED: begin
        v_we      = (32'(dst_row_r) < GRID_SIZE) && (32'(dst_col_r) < GRID_SIZE);
        v_waddr   = cell_idx(dst_row_r, dst_col_r);
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = {dst_row_r, dst_col_r};
        head_nxt  = '0;
        tail_nxt  = QCW'(1);
        state_nxt = S_POP;
      end

      // Dequeue the next cell, or give up with the source.
      S_POP: begin
        if (head_r == tail_r) begin
          res_nxt.next_row = src_row_r[3:0];
          res_nxt.next_col = src_col_r[3:0];
          res_nxt.found    = 1'b0;
          state_nxt        = S_OUT;
        end else begin
          head_nxt  = head_r + QCW'(1);
          state_nxt = S_CHECK;
        end
      end

      // Test the dequeued cell and read its first neighbor.
      S_CHECK: begin
        cur_row_nxt = base_row;
        cur_col_nxt = base_col;
        if (cheb_near(base_row, base_col, src_row_r, src_col_r)) begin
          res_nxt.next_row = base_row[3:0];
          res_nxt.next_col = base_col[3:0];
          res_nxt.found    = 1'b1;
          state_nxt        = S_OUT;
        end else begin
          nbr_k_nxt   = NB_DOWN;
          nbr_ok_nxt  = iss_ok;
          nbr_row_nxt = iss_row;
          nbr_col_nxt = iss_col;
          state_nxt   = S_NBR;
        end
      end

      // Map bits of one neighbor are back; enqueue it if free.
      S_NBR: begin
        if (nbr_ok_r && !b_rdata && !v_rdata) begin
          v_we     = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + QCW'(1);
        end
        if (nbr_k_r == NB_UP) begin
          state_nxt = S_POP;
        end else begin
          nbr_k_nxt   = iss_k;
          nbr_ok_nxt  = iss_ok;
          nbr_row_nxt = iss_row;
          nbr_col_nxt = iss_col;
        end
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: holds a result until its transfer.
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      init_r      <= 1'b1;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      init_r      <= init_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    src_row_r  <= src_row_nxt;
    src_col_r  <= src_col_nxt;
    dst_row_r  <= dst_row_nxt;
    dst_col_r  <= dst_col_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    nbr_k_r    <= nbr_k_nxt;
    nbr_ok_r   <= nbr_ok_nxt;
    nbr_row_r  <= nbr_row_nxt;
    nbr_col_r  <= nbr_col_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // A query transfer, a found result waiting to leave, and its distance test.
  assign query_xfer = in_xfer && (in_data.op == OP_QUERY);
  assign res_found  = (state_r == S_OUT) && res_r.found;
  assign res_near   = cheb_near(cur_row_r, cur_col_r, src_row_r, src_col_r);

  `GBFS_NEVER(a_head_past_tail, clk, rst_n, head_r > tail_r, "queue head passed tail")
  `GBFS_NEVER(a_queue_overflow, clk, rst_n, tail_r > QCW'(QD), "queue overflow")
  `GBFS_ASSERT(a_query_clears, clk, rst_n, query_xfer |=> (state_r == S_CLEAR), "no clear")
  `GBFS_ASSERT(a_found_near, clk, rst_n, res_found |-> res_near, "found cell not near source")

endmodule

// File: hdl/grid_bfs_next_step.sv
// Top level of the grid next-step search: register port plus search engine.
// Depends on gbfs_pkg, gbfs_cfg and gbfs_engine.
//
//   Port group   Direction  Handshake            Payload
//   in_*         input      in_valid / in_stall  in_item_t (load or query)
//   out_*        output     out_valid/out_stall  out_item_t (one per query)
//   APB          input      psel/penable/pready  grid_rows, grid_cols
//
// A load is taken in S_IDLE. A query sweeps the visited map, seeds the queue,
// expands each cell in turn (queue read, test, four neighbor reads of the map
// RAMs) and then passes its result on. After reset the blocked and visited
// maps are cleared in one pass, during which in_stall is high.
// A finished result waits in the output register; a new item is taken while
// it waits; a query halts before its result only while it is full and stalled.
module grid_bfs_next_step
  import gbfs_pkg::*;
#(
  parameter int GRID_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  grid_dim_t dim;

  gbfs_cfg #(.GRID_SIZE(GRID_SIZE)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dim     (dim)
  );

  gbfs_engine #(.GRID_SIZE(GRID_SIZE)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .dim       (dim),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
